FILE: rtl/dmx_pkg.sv
// Shared types, constants and helpers for the stereo downmix block.
`default_nettype none

package dmx_pkg;

    localparam int DMX_MAX_CHANNELS = 8;
    localparam int DMX_NUM_CH       = 8;
    localparam int SAMPLE_W         = 16;
    localparam int FRAC_BITS        = 12;
    localparam int GAIN_M3DB        = 2896;
    localparam int BASE_W           = SAMPLE_W + 2;
    localparam int MIX_W            = SAMPLE_W + 4;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 5;
    localparam int REG_IDX_W        = 3;

    localparam logic [2:0] REG_ENABLED       = 3'd0;
    localparam logic [2:0] REG_DOWNMIX_MODE  = 3'd1;
    localparam logic [2:0] REG_INPUT_LAYOUT  = 3'd2;
    localparam logic [2:0] REG_ACCUMULATE    = 3'd3;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd4;

    localparam logic MODE_STRIP = 1'b0;
    localparam logic MODE_FOLD  = 1'b1;

    localparam logic [2:0] LAYOUT_QUAD     = 3'd0;
    localparam logic [2:0] LAYOUT_SURROUND = 3'd1;
    localparam logic [2:0] LAYOUT_5_1      = 3'd2;
    localparam logic [2:0] LAYOUT_7_1      = 3'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [BASE_W-1:0]   base_t;

    typedef struct packed {
        logic       enabled;
        logic       downmix_mode;
        logic [2:0] input_layout;
        logic       accumulate;
        logic [3:0] channel_count;
    } dmx_cfg_t;

    // Clamp a widened mix back to the 16-bit sample range.
    function automatic sample_t sat16(input logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0] max_v;
        logic signed [MIX_W-1:0] min_v;
        max_v = MIX_W'(32767);
        min_v = -MIX_W'(32768);
        if (v > max_v)
        begin
            return sample_t'(32767);
        end
        else if (v < min_v)
        begin
            return sample_t'(-32768);
        end
        else
        begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dmx_regs.sv
// Configuration register file on an APB-style port.
`default_nettype none

module dmx_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dmx_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [dmx_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [dmx_pkg::APB_DATA_W-1:0]    prdata,
    output dmx_pkg::dmx_cfg_t                      cfg
);
    import dmx_pkg::*;

    dmx_cfg_t             cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled       <= 1'b0;
            cfg_reg.downmix_mode  <= MODE_FOLD;
            cfg_reg.input_layout  <= LAYOUT_7_1;
            cfg_reg.accumulate    <= 1'b1;
            cfg_reg.channel_count <= 4'd8;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ENABLED:       cfg_reg.enabled       <= pwdata[0];
                REG_DOWNMIX_MODE:  cfg_reg.downmix_mode  <= pwdata[0];
                REG_INPUT_LAYOUT:  cfg_reg.input_layout  <= pwdata[2:0];
                REG_ACCUMULATE:    cfg_reg.accumulate    <= pwdata[0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= pwdata[3:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLED:       prdata = {31'd0, cfg_reg.enabled};
            REG_DOWNMIX_MODE:  prdata = {31'd0, cfg_reg.downmix_mode};
            REG_INPUT_LAYOUT:  prdata = {29'd0, cfg_reg.input_layout};
            REG_ACCUMULATE:    prdata = {31'd0, cfg_reg.accumulate};
            REG_CHANNEL_COUNT: prdata = {28'd0, cfg_reg.channel_count};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/dmx_fold.sv
// Layout fold: front sums and the -3 dB centre term of one frame.
`default_nettype none

module dmx_fold (
    input  wire dmx_pkg::dmx_cfg_t cfg,
    input  wire dmx_pkg::sample_t  ch [dmx_pkg::DMX_NUM_CH],
    output dmx_pkg::base_t         lbase,
    output dmx_pkg::base_t         rbase,
    output dmx_pkg::base_t         cen
);
    import dmx_pkg::*;

    localparam int SUM_W  = SAMPLE_W + 1;
    localparam int PROD_W = SUM_W + 13;

    logic signed [SUM_W-1:0]  cen_sum;
    logic signed [PROD_W-1:0] cen_prod;
    logic                     use_cen;

    // Centre pair at Q12 gain; the Q12 floor is the upper product bits.
    assign cen_sum  = SUM_W'(ch[2]) + SUM_W'(ch[3]);
    assign cen_prod = PROD_W'(cen_sum) * PROD_W'(GAIN_M3DB);
    assign use_cen  = (cfg.downmix_mode == MODE_FOLD) && (cfg.input_layout != LAYOUT_QUAD);
    assign cen      = use_cen ? cen_prod[FRAC_BITS +: BASE_W] : '0;

    always_comb
    begin
        lbase = BASE_W'(ch[0]);
        rbase = BASE_W'(ch[1]);
        if (cfg.downmix_mode == MODE_FOLD)
        begin
            unique case (cfg.input_layout)
                LAYOUT_QUAD:
                begin
                    lbase = BASE_W'(ch[0]) + BASE_W'(ch[2]);
                    rbase = BASE_W'(ch[1]) + BASE_W'(ch[3]);
                end
                LAYOUT_5_1:
                begin
                    lbase = BASE_W'(ch[0]) + BASE_W'(ch[4]);
                    rbase = BASE_W'(ch[1]) + BASE_W'(ch[5]);
                end
                LAYOUT_7_1:
                begin
                    lbase = BASE_W'(ch[0]) + BASE_W'(ch[4]) + BASE_W'(ch[6]);
                    rbase = BASE_W'(ch[1]) + BASE_W'(ch[5]) + BASE_W'(ch[7]);
                end
                default:
                begin
                    lbase = BASE_W'(ch[0]);
                    rbase = BASE_W'(ch[1]);
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/multichannel_to_stereo_downmix_unit.sv
// Top level of the multichannel to stereo downmix unit.
//
// Input channel: in_valid / in_stall with eight channel samples and the
// existing stereo pair (prev_left, prev_right). A transaction is taken at a
// rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_left / out_right.
// Configuration: APB-style port, one 32-bit register per word
// (enabled, downmix_mode, input_layout, accumulate, channel_count).
// Path: an accepted transaction is held in the input register, then its result
// is loaded into the result register, which drives out_valid.
// Throughput: one frame per cycle while out_stall is low, set by the input
// register and the result register advancing together; the fold, centre gain,
// accumulate and saturation run as one combinational pass between them.
// A frame that gives no result (block disabled, or fold with an unsupported
// layout) is dropped at the input register and never reaches the output.
// Reset clears both valids and loads the register defaults (disabled,
// fold mode, 7.1 layout, accumulate on, eight channels).
// When the receiver stalls, the result register holds; the input register
// still takes a new transaction while either register has a bubble, so
// in_stall rises only once both are full and the output is stalled.
`default_nettype none

module multichannel_to_stereo_downmix_unit #(
    parameter int MAX_CHANNELS = dmx_pkg::DMX_MAX_CHANNELS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dmx_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dmx_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dmx_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire dmx_pkg::sample_t               front_left,
    input  wire dmx_pkg::sample_t               front_right,
    input  wire dmx_pkg::sample_t               chan_two,
    input  wire dmx_pkg::sample_t               chan_three,
    input  wire dmx_pkg::sample_t               rear_left,
    input  wire dmx_pkg::sample_t               rear_right,
    input  wire dmx_pkg::sample_t               side_left,
    input  wire dmx_pkg::sample_t               side_right,
    input  wire dmx_pkg::sample_t               prev_left,
    input  wire dmx_pkg::sample_t               prev_right,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output dmx_pkg::sample_t                    out_left,
    output dmx_pkg::sample_t                    out_right
);
    import dmx_pkg::*;

    dmx_cfg_t cfg;

    // Input register: masked input frame
    sample_t  ch_in     [DMX_NUM_CH];
    sample_t  ch_masked [DMX_NUM_CH];
    sample_t  ch_reg    [DMX_NUM_CH];
    sample_t  s1_prev_l_reg;
    sample_t  s1_prev_r_reg;
    logic     s1_valid_reg;
    logic     keep;

    // Fold terms, combinational from the input register
    base_t    lbase;
    base_t    rbase;
    base_t    cen;

    // Result register
    logic signed [MIX_W-1:0] mix_l;
    logic signed [MIX_W-1:0] mix_r;
    sample_t  out_left_reg;
    sample_t  out_right_reg;
    logic     out_valid_reg;

    logic     s1_ready;
    logic     s3_ready;

    dmx_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    assign ch_in[0] = front_left;
    assign ch_in[1] = front_right;
    assign ch_in[2] = chan_two;
    assign ch_in[3] = chan_three;
    assign ch_in[4] = rear_left;
    assign ch_in[5] = rear_right;
    assign ch_in[6] = side_left;
    assign ch_in[7] = side_right;

    // Zero channels at or beyond min(channel_count, MAX_CHANNELS).
    for (genvar i = 0; i < DMX_NUM_CH; i++)
    begin : g_mask
        assign ch_masked[i] = ((4'(i) < cfg.channel_count) && (i < MAX_CHANNELS))
                              ? ch_in[i] : '0;
    end

    // Drop frames that give no result before they enter the pipe.
    assign keep = cfg.enabled &&
                  ((cfg.downmix_mode == MODE_STRIP) || (cfg.input_layout <= LAYOUT_7_1));

    // Each register advances when it is empty or its successor moves.
    assign s3_ready = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || s3_ready;
    assign in_stall = !s1_ready;

    dmx_fold u_fold (
        .cfg   (cfg),
        .ch    (ch_reg),
        .lbase (lbase),
        .rbase (rbase),
        .cen   (cen)
    );

    // Accumulate adds the existing output pair after the Q12 floor.
    assign mix_l = MIX_W'(lbase) + MIX_W'(cen) +
                   (cfg.accumulate ? MIX_W'(s1_prev_l_reg) : '0);
    assign mix_r = MIX_W'(rbase) + MIX_W'(cen) +
                   (cfg.accumulate ? MIX_W'(s1_prev_r_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid && keep;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            ch_reg        <= ch_masked;
            s1_prev_l_reg <= prev_left;
            s1_prev_r_reg <= prev_right;
        end
        if (s3_ready && s1_valid_reg)
        begin
            out_left_reg  <= sat16(mix_l);
            out_right_reg <= sat16(mix_r);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    // A frame taken while disabled never fills the input stage.
    a_drop_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !cfg.enabled) |=> !s1_valid_reg)
        else $error("frame kept while disabled");

    // A result only appears after the input register held a frame.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("result without an input frame");

    // Input stalls only when both registers are full and the output is stalled.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with a bubble in the pipe");

endmodule

`default_nettype wire
